FILE: rtl/core/frequency_to_band_index_top_defines.svh
// Assertion macros shared by the frequency to band index RTL.
`ifndef FREQUENCY_TO_BAND_INDEX_TOP_DEFINES_SVH
`define FREQUENCY_TO_BAND_INDEX_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define FBI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbi assertion failed");

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define FBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbi assertion failed");

`endif

FILE: rtl/core/fbi_pkg.sv
// Types and constants of the frequency to band index block.
`default_nettype none
package fbi_pkg;

  localparam int FREQ_W     = 24;
  localparam int R_W        = 25;
  localparam int X_W        = 26;
  localparam int EW         = 5;
  localparam int MANT_FRAC  = 30;
  localparam int M_W        = 31;
  localparam int LOG_FRAC   = 24;
  localparam int LV_W       = EW + LOG_FRAC;
  localparam int V_W        = 32;
  localparam int NUM_W      = 62;
  localparam int DEN_W      = 32;
  localparam int BARK_QW    = 29;
  localparam int Y1_W       = 30;
  localparam int P1_W       = 61;
  localparam int CORR1_SH   = 37;
  localparam int P2_W       = 65;
  localparam int CORR2_SH   = 39;
  localparam int BARK_END   = BARK_QW + 4;
  localparam int LOG_PAD    = BARK_END - LOG_FRAC;
  localparam int MAP_LAT    = BARK_END + 2;

  localparam int BAND_W     = 11;
  localparam int IDX_W      = 10;
  localparam int MAX_BANDS  = 1024;
  localparam int QW         = $clog2(MAX_BANDS + 1);
  localparam int PROD_W     = V_W + BAND_W;
  localparam int PIPE_N     = MAP_LAT + 2 + QW;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HZ     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HZ     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TOTAL = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    SCALE_LOG  = 2'd0,
    SCALE_LIN  = 2'd1,
    SCALE_MEL  = 2'd2,
    SCALE_BARK = 2'd3
  } scale_t;

  localparam logic [FREQ_W-1:0] MIN_HZ_RST     = FREQ_W'(5120);
  localparam logic [FREQ_W-1:0] MAX_HZ_RST     = FREQ_W'(5120000);
  localparam logic [BAND_W-1:0] BAND_TOTAL_RST = BAND_W'(64);

  localparam logic [X_W-1:0]   MEL_OFFSET   = X_W'(179200);
  localparam logic [DEN_W-1:0] BARK_KNEE    = DEN_W'(501760);
  localparam logic [NUM_W-1:0] BARK_MUL     = NUM_W'(2681);
  localparam logic [DEN_W-1:0] BARK_DEN_MUL = DEN_W'(100);
  localparam logic signed [V_W-1:0] BARK_SUB  = 32'sd8891924;
  localparam logic signed [V_W-1:0] BARK_TWO  = 32'sd33554432;
  localparam logic signed [V_W-1:0] BARK_HIGH = 32'sd337221017;
  localparam logic [P1_W-1:0] RECIP1 = P1_W'(64'd1374389535);
  localparam logic [P2_W-1:0] RECIP2 = P2_W'(64'd5497558139);

endpackage
`default_nettype wire

FILE: rtl/core/fbi_in_if.sv
// Input channel carrying one frequency per transaction.
`default_nettype none
interface fbi_in_if;
  import fbi_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_hz;
  modport source (output valid, freq_hz, input ready);
  modport sink (input valid, freq_hz, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fbi_out_if.sv
// Result channel carrying the range flag and band number.
`default_nettype none
interface fbi_out_if;
  import fbi_pkg::*;
  logic             valid;
  logic             ready;
  logic             in_range;
  logic [IDX_W-1:0] band_index;
  modport source (output valid, in_range, band_index, input ready);
  modport sink (input valid, in_range, band_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fbi_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface fbi_cfg_if;
  import fbi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fbi_map.sv
// Pipelined mapping of one frequency to the log, linear, mel or bark domain.
`default_nettype none
module fbi_map (
  input  logic                             clk,
  input  logic                             en,
  input  fbi_pkg::scale_t                  mode,
  input  logic [fbi_pkg::R_W-1:0]          r,
  output logic signed [fbi_pkg::V_W-1:0]   map_val
);
  import fbi_pkg::*;

  logic [X_W-1:0]             x;
  logic [EW-1:0]              e;
  logic [X_W+MANT_FRAC-1:0]   xs;

  logic [M_W-1:0]   lm_r [0:LOG_FRAC];
  logic [LV_W-1:0]  lr_r [0:LOG_FRAC];
  logic [LV_W-1:0]  lp_r [0:LOG_PAD-1];
  logic [R_W-1:0]   rr_r [0:BARK_END];

  logic [NUM_W-1:0]   rem_r [0:BARK_QW];
  logic [DEN_W-1:0]   den_r [0:BARK_QW];
  logic [BARK_QW-1:0] q_r   [0:BARK_QW];

  logic signed [V_W-1:0] za;
  logic [V_W-1:0]        w1;
  logic [Y1_W-1:0]       y1;
  logic [P1_W-1:0]       p1;
  logic signed [V_W-1:0] za_r;
  logic                  lt_r;
  logic [P1_W-1-CORR1_SH:0] c1_r;

  logic signed [V_W-1:0] zb;
  logic [V_W-1:0]        w2;
  logic signed [V_W-1:0] zb_r;
  logic                  gt_r;
  logic [V_W-1:0]        y2_r;

  logic [P2_W-1:0]       p2;
  logic signed [V_W-1:0] zc_r;
  logic                  gtc_r;
  logic [P2_W-1-CORR2_SH:0] c2_r;

  logic signed [V_W-1:0] zd_r;
  logic signed [V_W-1:0] val_r;

  always_comb begin
    x = (mode == SCALE_MEL) ? X_W'(r) + MEL_OFFSET : X_W'(r);
    if (x == '0) begin
      x = X_W'(1);
    end
    e = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) begin
        e = EW'(i);
      end
    end
    xs = {x, {MANT_FRAC{1'b0}}} >> e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lm_r[0]  <= xs[M_W-1:0];
      lr_r[0]  <= {e, {LOG_FRAC{1'b0}}};
      rr_r[0]  <= r;
      rem_r[0] <= (NUM_W'(r) * BARK_MUL) << LOG_FRAC;
      den_r[0] <= (DEN_W'(r) + BARK_KNEE) * BARK_DEN_MUL;
      q_r[0]   <= '0;
      for (int i = 1; i <= BARK_END; i++) begin
        rr_r[i] <= rr_r[i-1];
      end
      lp_r[0] <= lr_r[LOG_FRAC];
      for (int i = 1; i < LOG_PAD; i++) begin
        lp_r[i] <= lp_r[i-1];
      end
    end
  end

  genvar k;
  for (k = 1; k <= LOG_FRAC; k++) begin : g_log
    logic [2*M_W-1:0]         sq;
    logic [2*M_W-MANT_FRAC-1:0] t;
    assign sq = (2*M_W)'(lm_r[k-1]) * (2*M_W)'(lm_r[k-1]);
    assign t  = sq[2*M_W-1:MANT_FRAC];
    always_ff @(posedge clk) begin
      if (en) begin
        if (t[M_W]) begin
          lm_r[k] <= t[M_W:1];
          lr_r[k] <= lr_r[k-1] | (LV_W'(1) << (LOG_FRAC - k));
        end else begin
          lm_r[k] <= t[M_W-1:0];
          lr_r[k] <= lr_r[k-1];
        end
      end
    end
  end

  for (k = 1; k <= BARK_QW; k++) begin : g_div
    logic [NUM_W-1:0] dsh;
    assign dsh = NUM_W'(den_r[k-1]) << (BARK_QW - k);
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_r[k-1];
        if (rem_r[k-1] >= dsh) begin
          rem_r[k] <= rem_r[k-1] - dsh;
          q_r[k]   <= q_r[k-1] | (BARK_QW'(1) << (BARK_QW - k));
        end else begin
          rem_r[k] <= rem_r[k-1];
          q_r[k]   <= q_r[k-1];
        end
      end
    end
  end

  always_comb begin
    za = $signed(V_W'(q_r[BARK_QW])) - BARK_SUB;
    w1 = V_W'(BARK_TWO - za);
    y1 = Y1_W'((w1 << 4) - w1);
    p1 = P1_W'(y1) * RECIP1;
    zb = lt_r ? za_r + $signed(V_W'(c1_r)) : za_r;
    w2 = V_W'(zb - BARK_HIGH);
    p2 = P2_W'(y2_r) * RECIP2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za_r  <= za;
      lt_r  <= za < BARK_TWO;
      c1_r  <= p1[P1_W-1:CORR1_SH];
      zb_r  <= zb;
      gt_r  <= zb > BARK_HIGH;
      y2_r  <= (w2 << 4) + (w2 << 2) + (w2 << 1);
      zc_r  <= zb_r;
      gtc_r <= gt_r;
      c2_r  <= p2[P2_W-1:CORR2_SH];
      zd_r  <= gtc_r ? zc_r + $signed(V_W'(c2_r)) : zc_r;
      case (mode)
        SCALE_LIN:  val_r <= $signed(V_W'(rr_r[BARK_END]));
        SCALE_BARK: val_r <= zd_r;
        default:    val_r <= $signed(V_W'(lp_r[LOG_PAD-1]));
      endcase
    end
  end

  assign map_val = val_r;

endmodule
`default_nettype wire

FILE: rtl/core/frequency_to_band_index_top.sv
// Top level of the frequency to band index block.
//
// The block sorts frequencies (unsigned Q16.8 Hz) into bands spread evenly
// over a log, linear, mel or bark domain between the configured limits.
// Each transaction on in_chan carries one frequency, and each transaction
// on out_chan returns its range flag and band number, in the same order.
// The configuration channel cfg_chan is always ready and writes one register
// per transaction; the user must write it only while no transaction is
// in flight, as the block does not enforce this. The pipeline takes one
// transaction per clock while the output is not stalled; its depth is set
// by the bark divider, one quotient bit per stage, then the band divider.
// All stages advance together: when a result waits on the output and the
// receiver holds ready low, in_chan.ready drops and nothing moves.
// A synchronous reset empties the pipeline and restores the default setup
// of log scale, 20 Hz to 20 kHz and 64 bands.
`default_nettype none
`include "frequency_to_band_index_top_defines.svh"
module frequency_to_band_index_top (
  input logic       clk,
  input logic       rst_n,
  fbi_in_if.sink    in_chan,
  fbi_out_if.source out_chan,
  fbi_cfg_if.sink   cfg_chan
);
  import fbi_pkg::*;

  scale_t            scale_mode_r;
  logic [FREQ_W-1:0] min_hz_r;
  logic [FREQ_W-1:0] max_hz_r;
  logic [BAND_W-1:0] band_total_r;

  logic [R_W-1:0]    lo_eff;
  logic [R_W-1:0]    hi_eff;
  logic [BAND_W-1:0] bands_eff;
  logic              en;
  logic              in_rng;

  logic              vld_r [0:PIPE_N-1];
  logic              rng_r [0:MAP_LAT-1];

  logic signed [V_W-1:0] v_val;
  logic signed [V_W-1:0] vmin_val;
  logic signed [V_W-1:0] vmax_val;

  logic [V_W-1:0]    off_r;
  logic [PROD_W-1:0] rem_r  [1:QW+1];
  logic [QW-1:0]     q_r    [1:QW+1];
  logic [V_W-1:0]    span_r [0:QW+1];
  logic              ok_r   [0:QW+1];
  logic              sat_r  [0:QW+1];
  logic              brng_r [0:QW+1];

  logic              out_valid_r;
  logic              out_range_r;
  logic [IDX_W-1:0]  out_band_r;

  always_comb begin
    lo_eff = (min_hz_r == '0) ? R_W'(1) : R_W'(min_hz_r);
    hi_eff = (R_W'(max_hz_r) < (lo_eff << 1)) ? (lo_eff << 1) : R_W'(max_hz_r);
    if (band_total_r == '0) begin
      bands_eff = BAND_W'(1);
    end else if (band_total_r > BAND_W'(MAX_BANDS)) begin
      bands_eff = BAND_W'(MAX_BANDS);
    end else begin
      bands_eff = band_total_r;
    end
    in_rng = (R_W'(in_chan.freq_hz) >= lo_eff) && (R_W'(in_chan.freq_hz) <= hi_eff);
    en     = !out_valid_r || out_chan.ready;
  end

  assign in_chan.ready  = en;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_mode_r <= SCALE_LOG;
      min_hz_r     <= MIN_HZ_RST;
      max_hz_r     <= MAX_HZ_RST;
      band_total_r <= BAND_TOTAL_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        REG_SCALE_MODE: scale_mode_r <= scale_t'(cfg_chan.wr_data[1:0]);
        REG_MIN_HZ:     min_hz_r     <= cfg_chan.wr_data;
        REG_MAX_HZ:     max_hz_r     <= cfg_chan.wr_data;
        REG_BAND_TOTAL: band_total_r <= cfg_chan.wr_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  fbi_map u_map_f (
    .clk     (clk),
    .en      (en),
    .mode    (scale_mode_r),
    .r       (R_W'(in_chan.freq_hz)),
    .map_val (v_val)
  );

  fbi_map u_map_lo (
    .clk     (clk),
    .en      (en),
    .mode    (scale_mode_r),
    .r       (lo_eff),
    .map_val (vmin_val)
  );

  fbi_map u_map_hi (
    .clk     (clk),
    .en      (en),
    .mode    (scale_mode_r),
    .r       (hi_eff),
    .map_val (vmax_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_N; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_chan.valid;
      for (int i = 1; i < PIPE_N; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rng_r[0] <= in_rng;
      for (int i = 1; i < MAP_LAT; i++) begin
        rng_r[i] <= rng_r[i-1];
      end
      brng_r[0]  <= rng_r[MAP_LAT-1];
      ok_r[0]    <= rng_r[MAP_LAT-1] && (vmax_val > vmin_val) && (v_val > vmin_val);
      sat_r[0]   <= V_W'(v_val - vmin_val) >= V_W'(vmax_val - vmin_val);
      off_r      <= V_W'(v_val - vmin_val);
      span_r[0]  <= V_W'(vmax_val - vmin_val);
      brng_r[1]  <= brng_r[0];
      ok_r[1]    <= ok_r[0];
      sat_r[1]   <= sat_r[0];
      span_r[1]  <= span_r[0];
      rem_r[1]   <= PROD_W'(off_r) * PROD_W'(bands_eff);
      q_r[1]     <= '0;
      out_range_r <= brng_r[QW+1];
      if (!ok_r[QW+1]) begin
        out_band_r <= '0;
      end else if (sat_r[QW+1]) begin
        out_band_r <= IDX_W'(bands_eff - BAND_W'(1));
      end else begin
        out_band_r <= IDX_W'(q_r[QW+1]);
      end
    end
  end

  genvar j;
  for (j = 2; j <= QW + 1; j++) begin : g_bdiv
    logic [PROD_W-1:0] dsh;
    assign dsh = PROD_W'(span_r[j-1]) << (QW + 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        brng_r[j] <= brng_r[j-1];
        ok_r[j]   <= ok_r[j-1];
        sat_r[j]  <= sat_r[j-1];
        span_r[j] <= span_r[j-1];
        if (rem_r[j-1] >= dsh) begin
          rem_r[j] <= rem_r[j-1] - dsh;
          q_r[j]   <= q_r[j-1] | (QW'(1) << (QW + 1 - j));
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= q_r[j-1];
        end
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.in_range   = out_range_r;
  assign out_chan.band_index = out_band_r;

  `FBI_ASSERT_NOW(a_stall_holds_input, out_valid_r && !out_chan.ready, !in_chan.ready)
  `FBI_ASSERT_NEXT(a_accept_enters_pipe, in_chan.valid && in_chan.ready, vld_r[0])
  `FBI_ASSERT_NOW(a_out_of_range_zero, out_valid_r && !out_range_r, out_band_r == '0)
  `FBI_ASSERT_NOW(a_band_below_count, out_valid_r, BAND_W'(out_band_r) < bands_eff)

endmodule
`default_nettype wire

FILE: tb/frequency_to_band_index_top_test.sv
// Self-checking testbench of the frequency to band index block, with its own band predictor.
`timescale 1ns / 100ps
`default_nettype none
module frequency_to_band_index_top_test;
  import fbi_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);

  typedef struct packed {
    logic             in_range;
    logic [IDX_W-1:0] band_index;
  } band_result_t;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    bit                typed;
    logic              in_range;
    logic [IDX_W-1:0]  band_index;
  } freq_row_t;

  logic clk;
  logic rst_n;

  fbi_in_if  in_chan ();
  fbi_out_if out_chan ();
  fbi_cfg_if cfg_chan ();

  frequency_to_band_index_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  scale_t            cur_scale;
  logic [FREQ_W-1:0] cur_min;
  logic [FREQ_W-1:0] cur_max;
  logic [BAND_W-1:0] cur_bands;

  band_result_t pending_bands[$];
  int           mismatches;
  int           items_sent;
  int           results_seen;
  int           in_range_seen;
  int           cycles;
  int           rx_stall;
  int           rx_draw;
  bit           quiet;

  freq_row_t directed_rows[] = '{
    '{24'd0,        1'b1, 1'b0, 10'd0},
    '{24'd5119,     1'b1, 1'b0, 10'd0},
    '{24'd5120,     1'b1, 1'b1, 10'd0},
    '{24'd5120000,  1'b1, 1'b1, 10'd63},
    '{24'd5120001,  1'b1, 1'b0, 10'd0},
    '{24'hFFFFFF,   1'b1, 1'b0, 10'd0},
    '{24'd5121,     1'b0, 1'b0, 10'd0},
    '{24'd10240,    1'b0, 1'b0, 10'd0},
    '{24'd256000,   1'b0, 1'b0, 10'd0},
    '{24'd2560000,  1'b0, 1'b0, 10'd0},
    '{24'd5119999,  1'b0, 1'b0, 10'd0},
    '{24'h555555,   1'b0, 1'b0, 10'd0},
    '{24'h2AAAAA,   1'b0, 1'b0, 10'd0},
    '{24'h0F0F0F,   1'b0, 1'b0, 10'd0}
  };

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint unsigned log2_fix(longint unsigned x);
    int                 e;
    longint unsigned    m;
    longint unsigned    acc;
    if (x == 0) x = 1;
    e = 0;
    while (e < 62 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    acc = longint'(e) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        acc = acc | (64'd1 << i);
      end
    end
    return acc;
  endfunction

  function automatic longint bark_fix(longint unsigned r);
    longint unsigned q;
    longint          z;
    q = ((64'd2681 * r) << 24) / (64'd100 * (64'(BARK_KNEE) + r));
    z = longint'(q) - longint'(BARK_SUB);
    if (z < longint'(BARK_TWO)) z = z + (15 * (longint'(BARK_TWO) - z)) / 100;
    if (z > longint'(BARK_HIGH)) z = z + (22 * (z - longint'(BARK_HIGH))) / 100;
    return z;
  endfunction

  function automatic longint map_to_domain(scale_t s, longint unsigned r);
    case (s)
      SCALE_LIN: return longint'(r);
      SCALE_MEL: return longint'(log2_fix(r + 64'(MEL_OFFSET)));
      SCALE_BARK: return bark_fix(r);
      default: return longint'(log2_fix(r));
    endcase
  endfunction

  function automatic longint unsigned eff_low();
    return (cur_min == 0) ? 64'd1 : 64'(cur_min);
  endfunction

  function automatic longint unsigned eff_high();
    longint unsigned lo;
    lo = eff_low();
    return (64'(cur_max) < 2 * lo) ? 2 * lo : 64'(cur_max);
  endfunction

  function automatic band_result_t predict_band(logic [FREQ_W-1:0] freq);
    band_result_t    res;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned nb;
    longint unsigned idx;
    longint          v;
    longint          vlo;
    longint          vhi;
    lo = eff_low();
    hi = eff_high();
    nb = (cur_bands == 0) ? 1 : 64'(cur_bands);
    if (nb > MAX_BANDS) nb = MAX_BANDS;
    res = '0;
    if (64'(freq) < lo || 64'(freq) > hi) return res;
    v = map_to_domain(cur_scale, 64'(freq));
    vlo = map_to_domain(cur_scale, lo);
    vhi = map_to_domain(cur_scale, hi);
    idx = 0;
    if (vhi > vlo && v > vlo) begin
      idx = (longint'(v - vlo) * nb) / longint'(vhi - vlo);
      if (idx >= nb) idx = nb - 1;
    end
    res.in_range = 1'b1;
    res.band_index = idx[IDX_W-1:0];
    return res;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.wr_data <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_SCALE_MODE: cur_scale = scale_t'(data[1:0]);
      REG_MIN_HZ: cur_min = data;
      REG_MAX_HZ: cur_max = data;
      REG_BAND_TOTAL: cur_bands = data[BAND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic configure(scale_t s, logic [23:0] lo, logic [23:0] hi, logic [23:0] nb);
    drain();
    cfg_write(REG_SCALE_MODE, CFG_DATA_W'(s));
    cfg_write(REG_MIN_HZ, lo);
    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_write(REG_MAX_HZ, hi);
    cfg_write(REG_BAND_TOTAL, nb);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic send_freq(logic [FREQ_W-1:0] freq, bit typed, band_result_t typed_res);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.freq_hz <= freq;
    do @(posedge clk); while (!in_chan.ready);
    pending_bands.push_back(typed ? typed_res : predict_band(freq));
    items_sent++;
  endtask

  function automatic logic [FREQ_W-1:0] draw_freq();
    longint unsigned lo;
    longint unsigned hi;
    int              pick;
    lo = eff_low();
    hi = eff_high();
    if (hi > 64'hFFFFFF) hi = 64'hFFFFFF;
    if (lo > 64'hFFFFFF) lo = 64'hFFFFFF;
    pick = $urandom_range(0, 9);
    if (pick < 7) return FREQ_W'($urandom_range(int'(hi), int'(lo)));
    if (pick == 7) return FREQ_W'($urandom_range(0, 1) ? lo : hi);
    return FREQ_W'($urandom);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("frequency_to_band_index_top_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_stall <= 0;
    end else if (out_chan.valid && out_chan.ready) begin
      if (pending_bands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction on the result channel.");
      end else begin
        band_result_t want;
        want = pending_bands.pop_front();
        if (out_chan.in_range !== want.in_range || out_chan.band_index !== want.band_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected in_range %0d band %0d, got in_range %0d band %0d.",
                     want.in_range, want.band_index, out_chan.in_range, out_chan.band_index);
        end
      end
      results_seen++;
      if (out_chan.in_range === 1'b1) in_range_seen++;
      rx_draw = quiet ? 0 : $urandom_range(0, 12);
      rx_stall <= rx_draw;
      out_chan.ready <= (rx_draw == 0);
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_chan.ready <= (rx_stall == 1);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  initial begin
    int wait_cycles;
    in_chan.valid = 1'b0;
    in_chan.freq_hz = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.reg_index = REG_SCALE_MODE;
    cfg_chan.wr_data = '0;
    out_chan.ready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    in_range_seen = 0;
    cycles = 0;
    quiet = 1'b0;
    cur_scale = SCALE_LOG;
    cur_min = MIN_HZ_RST;
    cur_max = MAX_HZ_RST;
    cur_bands = BAND_TOTAL_RST;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_freq(directed_rows[i].freq, directed_rows[i].typed,
                {directed_rows[i].in_range, directed_rows[i].band_index});

    configure(SCALE_LIN, 24'd0, 24'd0, 24'd0);
    send_freq(24'd0, 1'b1, '0);
    send_freq(24'd1, 1'b1, {1'b1, 10'd0});
    send_freq(24'd2, 1'b1, {1'b1, 10'd0});
    send_freq(24'd3, 1'b1, '0);
    configure(SCALE_MEL, 24'd1, 24'hFFFFFF, 24'd1024);
    send_freq(24'd1, 1'b1, {1'b1, 10'd0});
    send_freq(24'hFFFFFF, 1'b1, {1'b1, 10'd1023});
    send_freq(24'h800000, 1'b0, '0);
    configure(SCALE_BARK, 24'd100, 24'hFFFFFF, 24'd2047);
    send_freq(24'd100, 1'b1, {1'b1, 10'd0});
    send_freq(24'hFFFFFF, 1'b1, {1'b1, 10'd1023});
    send_freq(24'd600000, 1'b0, '0);
    configure(SCALE_LOG, 24'hFFFFFF, 24'd0, 24'd1);
    send_freq(24'hFFFFFF, 1'b1, {1'b1, 10'd0});
    send_freq(24'hFFFFFE, 1'b1, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      logic [23:0] lo;
      lo = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000));
      configure(scale_t'($urandom_range(0, 3)), lo, 24'($urandom),
                24'($urandom_range(0, 2047)));
      quiet = (p % 4 == 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_freq(draw_freq(), 1'b0, '0);
    end
    quiet = 1'b0;
    configure(SCALE_BARK, 24'd5120, 24'd5120000, 24'd1000);
    for (int k = 0; k < ITEMS_PER_PHASE; k++) send_freq(draw_freq(), 1'b0, '0);

    in_chan.valid <= 1'b0;
    wait_cycles = 0;
    while (pending_bands.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (pending_bands.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived.", pending_bands.size());
    end
    $display("Sent %0d frequencies over all four scales and %0d setups; %0d results, %0d in range.",
             items_sent, RANDOM_PHASES + 5, results_seen, in_range_seen);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("frequency_to_band_index_top_test: PASS");
    end else begin
      $display("frequency_to_band_index_top_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/fbi_pkg.sv
rtl/core/fbi_in_if.sv
rtl/core/fbi_out_if.sv
rtl/core/fbi_cfg_if.sv
rtl/core/fbi_map.sv
rtl/core/frequency_to_band_index_top.sv
tb/frequency_to_band_index_top_test.sv
